FILE: hdl/spu_pkg.sv
// Shared constants, codes and widths of the swarm particle update unit.
package spu_pkg;

  // Fixed-point format: Q15.16 coordinates, Q0.16 randoms, Q1.16 inertia gain and Q3.16 pull gains.
  localparam int FRAC_BITS     = 16;
  localparam int MAX_TERMS_DEF = 64;

  localparam int DATA_W      = 32;
  localparam int DIFF_W      = DATA_W + 1;
  localparam int RAND_W      = 16;
  localparam int LIM_W       = 31;
  localparam int W_GAIN_W    = 17;
  localparam int PULL_GAIN_W = 19;
  localparam int GSUM_W      = PULL_GAIN_W + 1;

  // Inner sum saturation width, accumulator and force sum widths.
  localparam int INNER_W = 46;
  localparam int ACC_W   = 48;
  localparam int FS_W    = 48;

  // Shared multiplier: signed A operand times unsigned B operand.
  localparam int MUL_A_W = INNER_W;
  localparam int MUL_B_W = GSUM_W;
  localparam int PROD_W  = MUL_A_W + MUL_B_W + 1;
  // Coefficient (gain*rand >> FRAC_BITS) width.
  localparam int K_W     = GSUM_W + RAND_W - FRAC_BITS;

  // Stream payload widths, padded to whole bytes.
  localparam int S_FIELDS_W = 4 * DATA_W + 2 * RAND_W + 2 * DATA_W + LIM_W;
  localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
  localparam int M_FIELDS_W = 2 * DATA_W + 1 + 2;
  localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = PULL_GAIN_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_UPDATE_MODE  = 2'd0,
    REG_INERTIA_GAIN = 2'd1,
    REG_OWN_GAIN     = 2'd2,
    REG_SOCIAL_GAIN  = 2'd3
  } cfg_reg_t;

  localparam logic [1:0] MODE_INERTIA   = 2'd0;
  localparam logic [1:0] MODE_CONSTRICT = 2'd1;
  localparam logic [1:0] MODE_FULL      = 2'd2;

  localparam logic [1:0] HIT_NONE  = 2'd0;
  localparam logic [1:0] HIT_LOWER = 2'd1;
  localparam logic [1:0] HIT_UPPER = 2'd2;

  localparam logic [1:0]             RST_UPDATE_MODE = MODE_CONSTRICT;
  localparam logic [W_GAIN_W-1:0]    RST_INERTIA     = 17'd47829;
  localparam logic [PULL_GAIN_W-1:0] RST_OWN_GAIN    = 19'd134349;
  localparam logic [PULL_GAIN_W-1:0] RST_SOCIAL_GAIN = 19'd134349;

endpackage

FILE: hdl/spu_mul.sv
// Shared signed-by-unsigned multiplier with a registered product.
module spu_mul (
  input  logic                                clk,
  input  logic signed [spu_pkg::MUL_A_W-1:0] a,
  input  logic        [spu_pkg::MUL_B_W-1:0] b,
  output logic signed [spu_pkg::PROD_W-1:0]  prod
);

  logic signed [spu_pkg::MUL_B_W:0] b_ext;

  assign b_ext = {1'b0, b};

  always_ff @(posedge clk) begin
    prod <= a * b_ext;
  end

endmodule

FILE: hdl/spu_div.sv
// Bit-serial restoring divider: signed dividend by unsigned count, truncating.
module spu_div #(
  parameter int DSR_W = 7
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic signed [spu_pkg::FS_W-1:0] dividend,
  input  logic        [DSR_W-1:0]          divisor,
  output logic                             done,
  output logic signed [spu_pkg::FS_W-1:0] quotient
);

  localparam int STEP_W = $clog2(spu_pkg::FS_W);

  logic                      busy;
  logic [STEP_W-1:0]         cnt;
  logic [spu_pkg::FS_W-1:0]  quo;
  logic [DSR_W-1:0]          rem;
  logic [DSR_W-1:0]          dsr;
  logic                      neg;
  logic [spu_pkg::FS_W-1:0]  mag;
  logic [DSR_W:0]            shifted;
  logic [DSR_W:0]            trial;
  logic                      fits;

  assign mag     = dividend[spu_pkg::FS_W-1] ? spu_pkg::FS_W'(-dividend)
                                             : spu_pkg::FS_W'(dividend);
  assign shifted = {rem, quo[spu_pkg::FS_W-1]};
  assign trial   = shifted - {1'b0, dsr};
  assign fits    = shifted >= {1'b0, dsr};
  assign quotient = neg ? $signed(-quo) : $signed(quo);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + STEP_W'(1);
        if (cnt == STEP_W'(spu_pkg::FS_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= mag;
      rem <= '0;
      dsr <= divisor;
      neg <= dividend[spu_pkg::FS_W-1];
    end else if (busy) begin
      quo <= {quo[spu_pkg::FS_W-2:0], fits};
      rem <= fits ? trial[DSR_W-1:0] : shifted[DSR_W-1:0];
    end
  end

endmodule

FILE: hdl/swarm_particle_update_unit.sv
// Swarm particle update unit: per-dimension velocity and position update, Q15.16.
// Inertia and constriction modes: five passes through the one multiplier plus limit and bound
// steps; a new item is accepted only once the unit is back in idle.
// Fully informed: a term without the last mark returns to idle after its force sum step; the last
// term also runs the 48-step serial divide of the force sum by the term count, then the multiply steps.
// A result not yet taken holds the unit in its bound step. Reset (rst, synchronous): registers
// to their defaults, force sum and term count to zero.
module swarm_particle_update_unit #(
  parameter int MAX_TERMS = spu_pkg::MAX_TERMS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // configuration write port
  input  logic                                cfg_we,
  input  logic [spu_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [spu_pkg::CFG_DATA_W-1:0]     cfg_data,
  // input stream
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // s_tdata from bit 0: pos_now, vel_now, own_best, neighbor_best, rand_a, rand_b,
  // lower_bound, upper_bound, vel_limit, zero pad
  input  logic [spu_pkg::S_TDATA_W-1:0]      s_tdata,
  input  logic                                s_tlast,   // last_term
  // result stream
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // m_tdata from bit 0: pos_next, vel_next, vel_clamped, bound_hit, zero pad
  output logic [spu_pkg::M_TDATA_W-1:0]      m_tdata
);

  localparam int DW     = spu_pkg::DATA_W;
  localparam int RW     = spu_pkg::RAND_W;
  localparam int ACC_W  = spu_pkg::ACC_W;
  localparam int FS_W   = spu_pkg::FS_W;
  localparam int INNER_W = spu_pkg::INNER_W;
  localparam int CNT_W  = $clog2(MAX_TERMS + 1);

  // Field offsets in s_tdata.
  localparam int OFS_POS  = 0;
  localparam int OFS_VEL  = OFS_POS + DW;
  localparam int OFS_OWN  = OFS_VEL + DW;
  localparam int OFS_NB   = OFS_OWN + DW;
  localparam int OFS_RA   = OFS_NB + DW;
  localparam int OFS_RB   = OFS_RA + RW;
  localparam int OFS_LB   = OFS_RB + RW;
  localparam int OFS_UB   = OFS_LB + DW;
  localparam int OFS_LIM  = OFS_UB + DW;

  // Sequencer. Each multiply state issues one product; the next state consumes it.
  typedef enum logic [12:0] {
    ST_IDLE    = 13'b0000000000001,
    ST_K1      = 13'b0000000000010,  // gain * rand_a
    ST_T1      = 13'b0000000000100,  // coef * first difference
    ST_K2      = 13'b0000000001000,  // first term to acc, social gain * rand_b
    ST_T2      = 13'b0000000010000,  // coef * neighbor difference
    ST_ACC2    = 13'b0000000100000,  // second term to acc
    ST_MULW    = 13'b0000001000000,  // w * (v or saturated inner sum)
    ST_SCALE   = 13'b0000010000000,  // scaled value to acc
    ST_LIMIT   = 13'b0000100000000,  // velocity limit
    ST_BOUND   = 13'b0001000000000,  // box correction, load output register
    ST_FSUM    = 13'b0010000000000,  // fully informed: accumulate neighbor term
    ST_DIVGO   = 13'b0100000000000,  // launch divide of force sum by term count
    ST_DIVWAIT = 13'b1000000000000   // wait for quotient, form inner sum
  } state_t;

  state_t state;
  state_t state_next;

  // Configuration registers.
  logic [1:0]                        update_mode;
  logic [spu_pkg::W_GAIN_W-1:0]      inertia_gain;
  logic [spu_pkg::PULL_GAIN_W-1:0]   own_gain;
  logic [spu_pkg::PULL_GAIN_W-1:0]   social_gain;

  // Item registers, captured on the input transaction.
  logic signed [DW-1:0]              pos;
  logic signed [DW-1:0]              vel;
  logic signed [spu_pkg::DIFF_W-1:0] diff_own;
  logic signed [spu_pkg::DIFF_W-1:0] diff_nb;
  logic [RW-1:0]                     rand_a;
  logic [RW-1:0]                     rand_b;
  logic signed [DW-1:0]              lower;
  logic signed [DW-1:0]              upper;
  logic [spu_pkg::LIM_W-1:0]         lim;
  logic                              last;
  logic [spu_pkg::GSUM_W-1:0]        gain_sum;

  // Working registers.
  logic signed [ACC_W-1:0]           acc;
  logic signed [DW-1:0]              vel_lim;
  logic                              clamped;
  logic signed [FS_W-1:0]            force_sum;
  logic [CNT_W-1:0]                  term_count;

  // Output register.
  logic [spu_pkg::M_FIELDS_W-1:0]    out_data;

  // Shared units.
  logic signed [spu_pkg::MUL_A_W-1:0] mul_a;
  logic [spu_pkg::MUL_B_W-1:0]        mul_b;
  logic signed [spu_pkg::PROD_W-1:0]  prod;
  logic                               div_start;
  logic                               div_done;
  logic signed [FS_W-1:0]             div_q;

  logic                              accept;
  logic                              mode_inertia;
  logic                              mode_full;
  logic [spu_pkg::K_W-1:0]           coef;
  logic signed [ACC_W-1:0]           term;
  logic signed [ACC_W-1:0]           acc_base;
  logic signed [ACC_W-1:0]           scale_base;
  logic signed [INNER_W-1:0]         acc_inner;
  logic signed [ACC_W:0]             q_sum;
  logic signed [INNER_W-1:0]         q_inner;
  logic signed [FS_W:0]              fs_sum;
  logic signed [FS_W-1:0]            fs_sat;
  logic signed [ACC_W-1:0]           lim_pos;
  logic signed [ACC_W-1:0]           lim_neg;
  logic                              over;
  logic                              under;
  logic signed [DW:0]                pos_sum;
  logic signed [DW:0]                lower_x;
  logic signed [DW:0]                upper_x;
  logic                              below;
  logic                              above;
  logic                              out_free;

  // Saturate to the inner-sum width.
  function automatic logic signed [INNER_W-1:0] sat_inner(input logic signed [ACC_W:0] val);
    logic [ACC_W-INNER_W+1:0] hi_bits;
    hi_bits = val[ACC_W:INNER_W-1];
    if (&hi_bits || ~|hi_bits) begin
      return val[INNER_W-1:0];
    end else if (val[ACC_W]) begin
      return {1'b1, {(INNER_W-1){1'b0}}};
    end else begin
      return {1'b0, {(INNER_W-1){1'b1}}};
    end
  endfunction

  assign accept       = s_tvalid && s_tready;
  assign s_tready     = (state == ST_IDLE) && !rst;
  assign mode_inertia = (update_mode == spu_pkg::MODE_INERTIA);
  assign mode_full    = (update_mode == spu_pkg::MODE_FULL);  // code 3 runs as constriction
  assign out_free     = !m_tvalid || m_tready;

  // Product slices: coefficient is (gain*rand) >> FRAC_BITS, always non-negative;
  // term is the floor shift of a signed product.
  assign coef = prod[spu_pkg::FRAC_BITS +: spu_pkg::K_W];
  assign term = prod[spu_pkg::FRAC_BITS +: ACC_W];

  assign acc_base   = mode_inertia ? '0 : ACC_W'(vel);
  assign scale_base = mode_inertia ? acc : '0;
  assign acc_inner  = sat_inner({acc[ACC_W-1], acc});
  assign q_sum      = (ACC_W+1)'(vel) + (ACC_W+1)'(div_q);
  assign q_inner    = sat_inner(q_sum);

  // Force sum add, saturating at 48 bits signed.
  assign fs_sum = {force_sum[FS_W-1], force_sum} + {term[ACC_W-1], term};
  always_comb begin
    if (fs_sum[FS_W] == fs_sum[FS_W-1]) begin
      fs_sat = fs_sum[FS_W-1:0];
    end else if (fs_sum[FS_W]) begin
      fs_sat = {1'b1, {(FS_W-1){1'b0}}};
    end else begin
      fs_sat = {1'b0, {(FS_W-1){1'b1}}};
    end
  end

  // Velocity limit. Comparing the wide value against the limit matches the
  // 32-bit saturation followed by the clamp, except that a high-side excess with
  // the limit at full scale is not flagged as clamped.
  assign lim_pos = ACC_W'(lim);
  assign lim_neg = -lim_pos;
  assign over    = acc > lim_pos;
  assign under   = acc < lim_neg;

  // Box correction, lower bound tested first.
  assign pos_sum = (DW+1)'(pos) + (DW+1)'(vel_lim);
  assign lower_x = (DW+1)'(lower);
  assign upper_x = (DW+1)'(upper);
  assign below   = pos_sum < lower_x;
  assign above   = pos_sum > upper_x;

  // Multiplier operand select.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_K1: begin
        mul_a = spu_pkg::MUL_A_W'(rand_a);
        mul_b = mode_full ? gain_sum : spu_pkg::MUL_B_W'(own_gain);
      end
      ST_T1: begin
        mul_a = mode_full ? spu_pkg::MUL_A_W'(diff_nb) : spu_pkg::MUL_A_W'(diff_own);
        mul_b = spu_pkg::MUL_B_W'(coef);
      end
      ST_K2: begin
        mul_a = spu_pkg::MUL_A_W'(rand_b);
        mul_b = spu_pkg::MUL_B_W'(social_gain);
      end
      ST_T2: begin
        mul_a = spu_pkg::MUL_A_W'(diff_nb);
        mul_b = spu_pkg::MUL_B_W'(coef);
      end
      ST_MULW: begin
        mul_a = mode_inertia ? spu_pkg::MUL_A_W'(vel) : acc_inner;
        mul_b = spu_pkg::MUL_B_W'(inertia_gain);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign div_start = (state == ST_DIVGO);

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:    if (accept) state_next = ST_K1;
      ST_K1:      state_next = ST_T1;
      ST_T1:      state_next = mode_full ? ST_FSUM : ST_K2;
      ST_K2:      state_next = ST_T2;
      ST_T2:      state_next = ST_ACC2;
      ST_ACC2:    state_next = ST_MULW;
      ST_MULW:    state_next = ST_SCALE;
      ST_SCALE:   state_next = ST_LIMIT;
      ST_LIMIT:   state_next = ST_BOUND;
      ST_BOUND:   if (out_free) state_next = ST_IDLE;
      ST_FSUM:    state_next = last ? ST_DIVGO : ST_IDLE;
      ST_DIVGO:   state_next = ST_DIVWAIT;
      ST_DIVWAIT: if (div_done) state_next = ST_MULW;
      default:    state_next = ST_IDLE;
    endcase
  end

  // Control state: sequencer, configuration, fully informed state, output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      update_mode  <= spu_pkg::RST_UPDATE_MODE;
      inertia_gain <= spu_pkg::RST_INERTIA;
      own_gain     <= spu_pkg::RST_OWN_GAIN;
      social_gain  <= spu_pkg::RST_SOCIAL_GAIN;
      force_sum    <= '0;
      term_count   <= '0;
      m_tvalid     <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_we) begin
        case (spu_pkg::cfg_reg_t'(cfg_index))
          spu_pkg::REG_UPDATE_MODE:  update_mode  <= cfg_data[1:0];
          spu_pkg::REG_INERTIA_GAIN: inertia_gain <= cfg_data[spu_pkg::W_GAIN_W-1:0];
          spu_pkg::REG_OWN_GAIN:     own_gain     <= cfg_data;
          spu_pkg::REG_SOCIAL_GAIN:  social_gain  <= cfg_data;
          default: ;
        endcase
      end

      // Terms beyond the maximum count are dropped.
      if (state == ST_FSUM && term_count < CNT_W'(MAX_TERMS)) begin
        force_sum  <= fs_sat;
        term_count <= term_count + CNT_W'(1);
      end
      // The last term has consumed the sum: clear for the next particle.
      if (state == ST_DIVWAIT && div_done) begin
        force_sum  <= '0;
        term_count <= '0;
      end

      if (state == ST_BOUND && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      pos      <= s_tdata[OFS_POS +: DW];
      vel      <= s_tdata[OFS_VEL +: DW];
      diff_own <= (spu_pkg::DIFF_W)'($signed(s_tdata[OFS_OWN +: DW]))
                - (spu_pkg::DIFF_W)'($signed(s_tdata[OFS_POS +: DW]));
      diff_nb  <= (spu_pkg::DIFF_W)'($signed(s_tdata[OFS_NB +: DW]))
                - (spu_pkg::DIFF_W)'($signed(s_tdata[OFS_POS +: DW]));
      rand_a   <= s_tdata[OFS_RA +: RW];
      rand_b   <= s_tdata[OFS_RB +: RW];
      lower    <= s_tdata[OFS_LB +: DW];
      upper    <= s_tdata[OFS_UB +: DW];
      lim      <= s_tdata[OFS_LIM +: spu_pkg::LIM_W];
      last     <= s_tlast;
      gain_sum <= spu_pkg::GSUM_W'(own_gain) + spu_pkg::GSUM_W'(social_gain);
    end

    case (state)
      ST_K2:    acc <= acc_base + term;
      ST_ACC2:  acc <= acc + term;
      ST_SCALE: acc <= scale_base + term;
      ST_DIVWAIT: begin
        if (div_done) begin
          acc <= ACC_W'(q_inner);
        end
      end
      ST_LIMIT: begin
        if (over) begin
          vel_lim <= DW'(lim);
          clamped <= (lim != {spu_pkg::LIM_W{1'b1}});
        end else if (under) begin
          vel_lim <= -DW'(lim);
          clamped <= 1'b1;
        end else begin
          vel_lim <= acc[DW-1:0];
          clamped <= 1'b0;
        end
      end
      ST_BOUND: begin
        if (out_free) begin
          if (below) begin
            out_data <= {spu_pkg::HIT_LOWER, clamped, {DW{1'b0}}, lower};
          end else if (above) begin
            out_data <= {spu_pkg::HIT_UPPER, clamped, {DW{1'b0}}, upper};
          end else begin
            out_data <= {spu_pkg::HIT_NONE, clamped, vel_lim, pos_sum[DW-1:0]};
          end
        end
      end
      default: ;
    endcase
  end

  assign m_tdata = {{(spu_pkg::M_TDATA_W - spu_pkg::M_FIELDS_W){1'b0}}, out_data};

  spu_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  spu_div #(
    .DSR_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (force_sum),
    .divisor  (term_count),
    .done     (div_done),
    .quotient (div_q)
  );

endmodule
